// ===== design/tga_rle_packet_encoder_macros.svh =====
// assertion macros for the run-length packet encoder
`ifndef TGA_RLE_PACKET_ENCODER_MACROS_SVH
`define TGA_RLE_PACKET_ENCODER_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define TRE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define TRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/tre_pkg.sv =====
// package with types and constants of the run-length packet encoder
`default_nettype none
package tre_pkg;
  localparam int MaxPacket = 128;
  localparam int PixPerRes = 4;
  localparam int RawAw = 7;
  localparam logic [1:0] ModeGrey = 2'd0;
  localparam logic [1:0] ModeBgr = 2'd1;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic        header_valid;
    logic [7:0]  header_byte;
    logic [2:0]  pixel_count;
    logic [31:0] pixel_a;
    logic [31:0] pixel_b;
    logic [31:0] pixel_c;
    logic [31:0] pixel_d;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [RawAw-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [RawAw-3:0] rrow;
  } raw_ctl_t;

  function automatic logic [31:0] mask_pixel(input logic [1:0] mode, input logic [31:0] p);
    logic [31:0] r;
    r = p;
    if (mode == ModeGrey) r = p & 32'h0000_00ff;
    else if (mode == ModeBgr) r = p & 32'h00ff_ffff;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/tre_raw_store.sv =====
// raw pixel memory: one pixel written, a row of four read per cycle
`default_nettype none
module tre_raw_store (
  input  wire logic                clk,
  input  wire tre_pkg::raw_ctl_t   ctl,
  output logic [4*32-1:0]          rdata
);
  logic [31:0] mem0 [0:tre_pkg::MaxPacket/4-1];
  logic [31:0] mem1 [0:tre_pkg::MaxPacket/4-1];
  logic [31:0] mem2 [0:tre_pkg::MaxPacket/4-1];
  logic [31:0] mem3 [0:tre_pkg::MaxPacket/4-1];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      case (ctl.waddr[1:0])
        2'd0: mem0[ctl.waddr[tre_pkg::RawAw-1:2]] <= ctl.wdata;
        2'd1: mem1[ctl.waddr[tre_pkg::RawAw-1:2]] <= ctl.wdata;
        2'd2: mem2[ctl.waddr[tre_pkg::RawAw-1:2]] <= ctl.wdata;
        default: mem3[ctl.waddr[tre_pkg::RawAw-1:2]] <= ctl.wdata;
      endcase
    end
    if (ctl.re) begin
      rdata <= {mem3[ctl.rrow], mem2[ctl.rrow], mem1[ctl.rrow], mem0[ctl.rrow]};
    end
  end
endmodule
`default_nettype wire

// ===== design/tga_rle_packet_encoder.sv =====
// top level of the run-length packet encoder
// One pixel per input transfer, packets out as result transfers of up to four pixels.
// A pixel is taken in the idle state and is always followed by a wait state, so a
// pixel that only fills the look-ahead window passes through idle and wait. Each queued
// pixel is written into the raw memory in the append state, followed by a wait state
// after the last of them (a row end can queue up to three). A run packet sent after the
// pixel passes through the run state and a wait state. A raw packet takes a memory read
// state, then the raw state once per result (ceil(count/4), at most 32 results), then a
// wait state. A run ended by a different pixel goes out with that pixel at no extra cost.
// A result waiting while out_ready is low stalls the sequencer. The raw pixels sit in
// a 128-entry memory read one row of four per cycle. Input is taken only while no packet
// is being sent. pixel_mode is sampled per pixel; write it only when idle.
`default_nettype none
`include "tga_rle_packet_encoder_macros.svh"
module tga_rle_packet_encoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tre_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tre_pkg::out_item_t      out_data
);
  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take a pixel
  localparam logic [2:0] S_RUN  = 3'd1;  // send a run packet
  localparam logic [2:0] S_RD   = 3'd2;  // issue raw row read
  localparam logic [2:0] S_RAW  = 3'd3;  // send raw results
  localparam logic [2:0] S_APP  = 3'd4;  // append queued pixels
  localparam logic [2:0] S_WAIT = 3'd5;  // wait for output register

  logic [1:0]  pixel_mode;
  logic [2:0]  state;
  logic [31:0] win0, win1;
  logic [1:0]  wfill;
  logic [7:0]  raw_count;
  logic [31:0] run_pixel;
  logic [7:0]  run_count;
  logic        in_run;
  // pending work from the pixel just taken
  logic        pend_flush;   // flush raw before anything else
  logic        pend_run;     // emit run after flush
  logic [1:0]  q_n;          // queued appends
  logic [31:0] q0, q1, q2;
  logic        pend_end;     // row end: final flush
  // raw drain
  logic [7:0]  drain_total;
  logic [7:0]  drain_pos;
  logic [4*32-1:0] rdata;
  tre_pkg::raw_ctl_t ctl;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free && !pend_flush && !pend_run
                    && (q_n == 2'd0) && !pend_end;

  tre_raw_store u_store (.clk(clk), .ctl(ctl), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (rst) pixel_mode <= 2'd0;
    else if (cfg_we) pixel_mode <= cfg_data;
  end

  // any more output still owed after the current step
  function automatic logic more_after(input logic pf, input logic pr,
                                      input logic [1:0] qn, input logic pe,
                                      input logic [7:0] rc);
    return pf || pr || (qn != 2'd0) || (pe && rc != 8'd0);
  endfunction

  // one result transfer built from its fields
  function automatic tre_pkg::out_item_t make_result(
      input logic hv, input logic [7:0] hb, input logic [2:0] pn,
      input logic [31:0] xa, input logic [31:0] xb, input logic [31:0] xc,
      input logic [31:0] xd, input logic lr);
    tre_pkg::out_item_t r;
    r = '0;
    r.header_valid = hv;
    r.header_byte = hb;
    r.pixel_count = pn;
    r.pixel_a = xa;
    r.pixel_b = xb;
    r.pixel_c = xc;
    r.pixel_d = xd;
    r.last_result = lr;
    return r;
  endfunction

  logic [31:0] p;
  logic [7:0]  rem;
  logic [2:0]  cnt;

  always_comb begin
    p = tre_pkg::mask_pixel(pixel_mode, in_data.pixel_value);
    rem = drain_total - drain_pos;
    cnt = (rem > 8'd4) ? 3'd4 : rem[2:0];
    ctl = '0;
    ctl.rrow = drain_pos[tre_pkg::RawAw-1:2];
    if (state == S_RD || (state == S_RAW && out_free && rem > 8'd4)) ctl.re = 1'b1;
    if (state == S_RAW && out_free && rem > 8'd4)
      ctl.rrow = drain_pos[tre_pkg::RawAw-1:2] + 5'd1;
    if (state == S_APP && raw_count < 8'(tre_pkg::MaxPacket)) begin
      ctl.we = 1'b1;
      ctl.waddr = raw_count[tre_pkg::RawAw-1:0];
      ctl.wdata = q0;
    end
  end

  // a held run broken by a different pixel, or by a full count
  logic run_break;
  logic out_load;
  assign run_break = in_run && !(p == run_pixel && run_count < 8'(tre_pkg::MaxPacket));
  assign out_load = (state == S_IDLE && in_valid && in_ready && run_break)
                    || ((state == S_RUN || state == S_RAW) && out_free);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; wfill <= 2'd0; raw_count <= 8'd0;
      run_count <= 8'd0; in_run <= 1'b0; pend_flush <= 1'b0; pend_run <= 1'b0;
      q_n <= 2'd0; pend_end <= 1'b0;
      drain_total <= 8'd0; drain_pos <= 8'd0; win0 <= '0; win1 <= '0; run_pixel <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            logic fresh, pf, pr, emit_old;
            logic [1:0] qn;
            logic [31:0] a0, a1, a2;
            logic [1:0] wf;
            logic [31:0] w0, w1;
            fresh = 1'b1; pf = 1'b0; pr = 1'b0; emit_old = 1'b0; qn = 2'd0;
            a0 = '0; a1 = '0; a2 = '0; wf = wfill; w0 = win0; w1 = win1;
            if (in_run) begin
              if (p == run_pixel && run_count < 8'(tre_pkg::MaxPacket)) begin
                run_count <= run_count + 8'd1; fresh = 1'b0;
                if (run_count + 8'd1 >= 8'(tre_pkg::MaxPacket) || in_data.row_end)
                  pr = 1'b1;
              end else emit_old = 1'b1;
            end
            if (fresh) begin
              if (wf == 2'd2) begin
                if (w0 == w1 && w1 == p) begin
                  pf = 1'b1; wf = 2'd0;
                  pr = in_data.row_end;
                end else begin
                  qn = 2'd1; a0 = w0; w0 = w1; w1 = p;
                end
              end else if (wf == 2'd0) begin
                w0 = p; wf = 2'd1;
              end else begin
                w1 = p; wf = 2'd2;
              end
            end
            if (in_data.row_end) begin
              // window pixels follow the one already queued
              if (qn == 2'd1) begin
                if (wf == 2'd2) begin qn = 2'd3; a1 = w0; a2 = w1; end
              end else if (wf == 2'd1) begin qn = 2'd1; a0 = w0; end
              else if (wf == 2'd2) begin qn = 2'd2; a0 = w0; a1 = w1; end
              wf = 2'd0;
            end
            win0 <= w0; win1 <= w1; wfill <= wf;
            q_n <= qn; q0 <= a0; q1 <= a1; q2 <= a2;
            pend_end <= in_data.row_end;
            if (emit_old) begin
              // old run goes out now, new pixel follows fresh
              out_data <= make_result(1'b1, 8'h80 | {1'b0, run_count[6:0] - 7'd1}, 3'd1,
                                      run_pixel, 32'd0, 32'd0, 32'd0,
                                      !more_after(pf, pr, qn, in_data.row_end, raw_count)
                                      && !(pf && raw_count != 8'd0));
              in_run <= 1'b0;
            end
            if (pf) begin
              in_run <= 1'b1; run_pixel <= p; run_count <= 8'd3;
            end
            pend_flush <= pf; pend_run <= pr;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            if (pend_flush) begin
              pend_flush <= 1'b0;
              if (raw_count != 8'd0) begin
                drain_total <= raw_count; drain_pos <= 8'd0; state <= S_RD;
              end
            end else if (pend_run) begin
              state <= S_RUN;
            end else if (q_n != 2'd0) begin
              state <= S_APP;
            end else if (pend_end) begin
              pend_end <= 1'b0;
              if (raw_count != 8'd0) begin
                drain_total <= raw_count; drain_pos <= 8'd0; state <= S_RD;
              end else state <= S_IDLE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RUN: begin
          if (out_free) begin
            out_data <= make_result(1'b1, 8'h80 | {1'b0, run_count[6:0] - 7'd1}, 3'd1,
                                    run_pixel, 32'd0, 32'd0, 32'd0,
                                    !more_after(1'b0, 1'b0, q_n, pend_end, raw_count));
            in_run <= 1'b0; run_count <= 8'd0; pend_run <= 1'b0;
            state <= S_WAIT;
          end
        end
        S_APP: begin
          if (raw_count >= 8'(tre_pkg::MaxPacket)) begin
            drain_total <= raw_count; drain_pos <= 8'd0; state <= S_RD;
          end else begin
            raw_count <= raw_count + 8'd1;
            q0 <= q1; q1 <= q2; q_n <= q_n - 2'd1;
            if (raw_count + 8'd1 >= 8'(tre_pkg::MaxPacket)) begin
              drain_total <= raw_count + 8'd1; drain_pos <= 8'd0; state <= S_RD;
            end else if (q_n == 2'd1) state <= S_WAIT;
          end
        end
        S_RD: begin
          state <= S_RAW;
        end
        S_RAW: begin
          if (out_free) begin
            // a row end flush after this one would find the raw memory empty
            out_data <= make_result(drain_pos == 8'd0,
                                    (drain_pos == 8'd0) ?
                                    {1'b0, drain_total[6:0] - 7'd1} : 8'd0,
                                    cnt, rdata[31:0],
                                    (cnt > 3'd1) ? rdata[63:32] : 32'd0,
                                    (cnt > 3'd2) ? rdata[95:64] : 32'd0,
                                    (cnt > 3'd3) ? rdata[127:96] : 32'd0,
                                    (rem > 8'd4) ? 1'b0 : !(pend_run || q_n != 2'd0));
            if (rem > 8'd4) begin
              drain_pos <= drain_pos + 8'd4;
            end else begin
              raw_count <= 8'd0;
              state <= (q_n != 2'd0 && raw_count >= 8'(tre_pkg::MaxPacket)
                        && pend_flush == 1'b0) ? S_APP : S_WAIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRE_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")
  `TRE_ASSERT_IMP(a_raw_bound, clk, rst, 1'b1, raw_count <= 8'(tre_pkg::MaxPacket),
    "raw count over limit")
  `TRE_ASSERT_IMP(a_cnt_range, clk, rst, out_valid, out_data.pixel_count <= 3'd4,
    "bad pixel count")
  `TRE_ASSERT_NEXT(a_rd_raw, clk, rst, state == S_RD, state == S_RAW, "read not followed")
endmodule
`default_nettype wire
